// ===== design/kcsv_pkg.sv =====
// Shared types, key strings and helpers for the keyed CSV field parser.
package kcsv_pkg;

    localparam int HIST_DEPTH = 6;

    localparam logic [31:0] KEY_LEN    = "len=";
    localparam logic [55:0] KEY_FRAMES = "frames=";
    localparam logic [47:0] KEY_CRC    = "crc32=";

    localparam logic [31:0] FRAMES_MAX     = 32'h0000_FFFF;
    localparam logic [3:0]  CRC_MAX_DIGITS = 4'd8;
    localparam logic [3:0]  CRC_CNT_SAT    = 4'd9;

    // Operation codes carried with each byte
    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_READ   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    // Post-update view of a decimal field tracker
    typedef struct packed {
        logic        found;
        logic        seen;
        logic [31:0] acc;
    } dec_status_t;

    // acc * 10 + digit, wrapping at 32 bits
    function automatic logic [31:0] dec_shift_add(input logic [31:0] acc,
                                                  input logic [3:0]  digit);
        dec_shift_add = (acc << 3) + (acc << 1) + {28'd0, digit};
    endfunction

endpackage

// ===== design/kcsv_dec_track.sv =====
// Decimal field tracker: waits for its key, then accumulates the digits after it.
module kcsv_dec_track
    import kcsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        clear,
    input  logic        is_digit,
    input  logic [3:0]  digit,
    input  logic        key_hit,
    output dec_status_t status
);

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic        seen_reg, seen_next;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (key_hit)
                begin
                    phase_next = PH_READ;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                end
            end
            PH_READ:
            begin
                if (is_digit)
                begin
                    acc_next  = dec_shift_add(acc_reg, digit);
                    seen_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase
    end

    assign status.found = (phase_next != PH_SEARCH);
    assign status.seen  = seen_next;
    assign status.acc   = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            // drop everything once the payload closes
            if (clear)
            begin
                phase_reg <= PH_SEARCH;
                acc_reg   <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

// ===== design/keyed_csv_field_parser.sv =====
// Top level of the keyed CSV field parser.
// Bytes of a text payload enter one per beat on the byte channel; the beat with last set
// closes the payload and produces one result beat. In start mode the payload must carry
// "len=" and "frames=" with decimal digits and "crc32=" with one to eight hex digits
// (first occurrence of each key decides); in end mode only "crc32=" counts. A byte is
// taken every cycle: it is registered, then one pass of compare and shift-add logic updates
// the three field trackers and, on the last byte, loads the result register. The result
// is registered behind the byte stage, and bytes keep flowing while a result waits; only a
// second last byte stalls until the waiting result is taken.
module keyed_csv_field_parser
    import kcsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic        operation,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        ok,
    output logic [31:0] total_len,
    output logic [15:0] frames,
    output logic [31:0] crc_value
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_op_reg;
    logic       advance;

    logic [7:0] hist_reg [HIST_DEPTH];

    logic        result_valid_reg;
    logic        ok_reg;
    logic [31:0] total_len_reg;
    logic [15:0] frames_reg;
    logic [31:0] crc_value_reg;

    phase_t      crc_phase_reg, crc_phase_next;
    logic [31:0] crc_acc_reg, crc_acc_next;
    logic [3:0]  crc_cnt_reg, crc_cnt_next;

    logic        is_dec, is_hex;
    logic [3:0]  nibble;
    logic        hit_len, hit_frames, hit_crc;
    dec_status_t len_status, frames_status;
    logic        ok_len, ok_frames, ok_crc, ok_next;

    // Advance the byte stage unless a last byte would land on a full result register
    assign advance    = s1_valid_reg && (!s1_last_reg || !result_valid_reg || result_ready);
    assign byte_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last;
            s1_op_reg   <= operation;
        end
    end

    // Character classes
    always_comb
    begin
        is_dec = (s1_byte_reg >= 8'h30) && (s1_byte_reg <= 8'h39);
        is_hex = is_dec
              || ((s1_byte_reg >= 8'h41) && (s1_byte_reg <= 8'h46))
              || ((s1_byte_reg >= 8'h61) && (s1_byte_reg <= 8'h66));
        nibble = is_dec ? s1_byte_reg[3:0] : (s1_byte_reg[3:0] + 4'd9);
    end

    // Key windows end at the current byte
    assign hit_len    = ({hist_reg[3], hist_reg[4], hist_reg[5], s1_byte_reg} == KEY_LEN);
    assign hit_frames = ({hist_reg[0], hist_reg[1], hist_reg[2], hist_reg[3],
                          hist_reg[4], hist_reg[5], s1_byte_reg} == KEY_FRAMES);
    assign hit_crc    = ({hist_reg[1], hist_reg[2], hist_reg[3],
                          hist_reg[4], hist_reg[5], s1_byte_reg} == KEY_CRC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
            begin
                hist_reg[i] <= s1_last_reg ? 8'd0 : hist_reg[i + 1];
            end
            hist_reg[HIST_DEPTH - 1] <= s1_last_reg ? 8'd0 : s1_byte_reg;
        end
    end

    kcsv_dec_track u_len_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .clear    (s1_last_reg),
        .is_digit (is_dec),
        .digit    (s1_byte_reg[3:0]),
        .key_hit  (hit_len),
        .status   (len_status)
    );

    kcsv_dec_track u_frames_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .clear    (s1_last_reg),
        .is_digit (is_dec),
        .digit    (s1_byte_reg[3:0]),
        .key_hit  (hit_frames),
        .status   (frames_status)
    );

    // Hex tracker for the crc field
    always_comb
    begin
        crc_phase_next = crc_phase_reg;
        crc_acc_next   = crc_acc_reg;
        crc_cnt_next   = crc_cnt_reg;
        unique case (crc_phase_reg)
            PH_SEARCH:
            begin
                if (hit_crc)
                begin
                    crc_phase_next = PH_READ;
                    crc_acc_next   = '0;
                    crc_cnt_next   = '0;
                end
            end
            PH_READ:
            begin
                if (is_hex)
                begin
                    crc_acc_next = {crc_acc_reg[27:0], nibble};
                    if (crc_cnt_reg < CRC_CNT_SAT)
                    begin
                        crc_cnt_next = crc_cnt_reg + 4'd1;
                    end
                end
                else
                begin
                    crc_phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                crc_phase_next = PH_DONE;
            end
            default:
            begin
                crc_phase_next = PH_SEARCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_phase_reg <= PH_SEARCH;
            crc_acc_reg   <= '0;
            crc_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                crc_phase_reg <= PH_SEARCH;
                crc_acc_reg   <= '0;
                crc_cnt_reg   <= '0;
            end
            else
            begin
                crc_phase_reg <= crc_phase_next;
                crc_acc_reg   <= crc_acc_next;
                crc_cnt_reg   <= crc_cnt_next;
            end
        end
    end

    always_comb
    begin
        ok_len    = len_status.found && len_status.seen;
        ok_frames = frames_status.found && frames_status.seen
                 && (frames_status.acc <= FRAMES_MAX);
        ok_crc    = (crc_phase_next != PH_SEARCH) && (crc_cnt_next != 4'd0)
                 && (crc_cnt_next <= CRC_MAX_DIGITS);
        ok_next   = (s1_op_reg == OP_END) ? ok_crc : (ok_len && ok_frames && ok_crc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && s1_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
        begin
            ok_reg        <= ok_next;
            total_len_reg <= (ok_next && s1_op_reg == OP_START) ? len_status.acc : 32'd0;
            frames_reg    <= (ok_next && s1_op_reg == OP_START) ? frames_status.acc[15:0]
                                                                : 16'd0;
            crc_value_reg <= ok_next ? crc_acc_next : 32'd0;
        end
    end

    assign result_valid = result_valid_reg;
    assign ok           = ok_reg;
    assign total_len    = total_len_reg;
    assign frames       = frames_reg;
    assign crc_value    = crc_value_reg;

endmodule

// ===== design/kcsv_checker.sv =====
// Port-level checker for the keyed CSV field parser, bound to the top level.
module kcsv_props
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_ready,
    input logic        last,
    input logic        result_valid,
    input logic        result_ready,
    input logic        ok,
    input logic [31:0] total_len,
    input logic [15:0] frames,
    input logic [31:0] crc_value
);

    // A stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(ok)
        && $stable(total_len) && $stable(frames) && $stable(crc_value))
        else $error("result beat changed while stalled");

    // A failed payload reports zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ok |-> total_len == 32'd0 && frames == 16'd0 && crc_value == 32'd0)
        else $error("nonzero fields on failed result");

    // A fresh result follows a taken last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_valid && byte_ready && last, 2))
        else $error("result without a closing byte");

    // An empty result register never holds off bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> byte_ready)
        else $error("byte stalled with empty result register");

endmodule

bind keyed_csv_field_parser kcsv_props u_kcsv_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ok           (ok),
    .total_len    (total_len),
    .frames       (frames),
    .crc_value    (crc_value)
);
